[hw/rtl/frustum_aabb_cull_core_defines.svh]
// Assertion macros for the frustum cull core checker.
`ifndef FRUSTUM_AABB_CULL_CORE_DEFINES_SVH
`define FRUSTUM_AABB_CULL_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define FAC_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define FAC_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

[hw/rtl/fac_pkg.sv]
// Shared types and constants for the frustum cull core.
package fac_pkg;
    localparam int MAT_W   = 16;
    localparam int ELEM_W  = 34;
    localparam int PLANE_W = 35;
    localparam int NREG    = 8;
    localparam int NPLANE  = 6;
    localparam logic [2:0] IDX_PROJ0 = 3'd0;
    localparam logic [63:0] RST_COL0 = 64'h0000_0000_0000_1000;
    localparam logic [63:0] RST_COL1 = 64'h0000_0000_1000_0000;
    localparam logic [63:0] RST_COL2 = 64'h0000_1000_0000_0000;
    localparam logic [63:0] RST_COL3 = 64'h1000_0000_0000_0000;

    typedef logic signed [PLANE_W-1:0] plane_t [4];

    function automatic logic signed [MAT_W-1:0] entry(input logic [63:0] r,
                                                      input int row);
        return r[16*row +: 16];
    endfunction
endpackage

[hw/rtl/fac_plane_gen.sv]
// Matrix product and plane extraction from the configuration registers.
module fac_plane_gen (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [3:0]   wr_index,
    input  logic [63:0]  wr_data,
    output fac_pkg::plane_t planes [fac_pkg::NPLANE]
);
    logic [63:0] proj_reg [4];
    logic [63:0] view_reg [4];
    logic signed [fac_pkg::ELEM_W-1:0] m_reg [4][4];
    logic signed [fac_pkg::ELEM_W-1:0] m_next [4][4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proj_reg[0] <= fac_pkg::RST_COL0;
            proj_reg[1] <= fac_pkg::RST_COL1;
            proj_reg[2] <= fac_pkg::RST_COL2;
            proj_reg[3] <= fac_pkg::RST_COL3;
            view_reg[0] <= fac_pkg::RST_COL0;
            view_reg[1] <= fac_pkg::RST_COL1;
            view_reg[2] <= fac_pkg::RST_COL2;
            view_reg[3] <= fac_pkg::RST_COL3;
        end
        else if (wr_en && wr_index < 4'(fac_pkg::NREG))
        begin
            if (wr_index[2] == 1'b0)
                proj_reg[wr_index[1:0]] <= wr_data;
            else
                view_reg[wr_index[1:0]] <= wr_data;
        end
    end

    // 64 small 16x16 products; config is quasi-static, one register stage
    always_comb
    begin
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                m_next[c][r] = '0;
                for (int k = 0; k < 4; k++)
                    m_next[c][r] = m_next[c][r]
                        + fac_pkg::ELEM_W'(fac_pkg::entry(proj_reg[k], r))
                        * fac_pkg::ELEM_W'(fac_pkg::entry(view_reg[c], k));
            end
    end

    always_ff @(posedge clk)
        m_reg <= m_next;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            planes[0][c] = fac_pkg::PLANE_W'(m_reg[c][3]) + fac_pkg::PLANE_W'(m_reg[c][0]);
            planes[1][c] = fac_pkg::PLANE_W'(m_reg[c][3]) - fac_pkg::PLANE_W'(m_reg[c][0]);
            planes[2][c] = fac_pkg::PLANE_W'(m_reg[c][3]) - fac_pkg::PLANE_W'(m_reg[c][1]);
            planes[3][c] = fac_pkg::PLANE_W'(m_reg[c][3]) + fac_pkg::PLANE_W'(m_reg[c][1]);
            planes[4][c] = fac_pkg::PLANE_W'(m_reg[c][3]) + fac_pkg::PLANE_W'(m_reg[c][2]);
            planes[5][c] = fac_pkg::PLANE_W'(m_reg[c][3]) - fac_pkg::PLANE_W'(m_reg[c][2]);
        end
    end
endmodule

[hw/rtl/fac_cell.sv]
// One plane test cell: passes the box on and ANDs its verdict into the chain.
module fac_cell #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          en,
    input  fac_pkg::plane_t               plane,
    input  logic [6*COORD_WIDTH-1:0]      box_in,
    input  logic                          ok_in,
    output logic [6*COORD_WIDTH-1:0]      box_out,
    output logic                          ok_out
);
    localparam int PW = fac_pkg::PLANE_W + COORD_WIDTH + 3;
    logic signed [PW-1:0] best;
    logic signed [COORD_WIDTH-1:0] lo [3];
    logic signed [COORD_WIDTH-1:0] hi [3];
    logic [6*COORD_WIDTH-1:0] box_reg;
    logic ok_reg;

    // best corner: per axis pick the coordinate maximizing the term
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lo[k] = box_in[k*COORD_WIDTH +: COORD_WIDTH];
            hi[k] = box_in[(k+3)*COORD_WIDTH +: COORD_WIDTH];
        end
        best = PW'(plane[3]) <<< 4;
        for (int k = 0; k < 3; k++)
        begin
            if (plane[k] < 0)
                best = best + PW'(plane[k]) * PW'(hi[k] < lo[k] ? hi[k] : lo[k]);
            else
                best = best + PW'(plane[k]) * PW'(hi[k] > lo[k] ? hi[k] : lo[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            box_reg <= box_in;
            ok_reg  <= ok_in && (best > 0);
        end
    end

    assign box_out = box_reg;
    assign ok_out  = ok_reg;
endmodule

[hw/rtl/frustum_aabb_cull_core.sv]
// Top level of the frustum cull core: config, plane generation, cell chain.
// One registered cell per clip plane lies on the path from input item to result.
// Throughput: one box per cycle; the chain stalls as a whole when the
// output is held, even when earlier slots are empty.
// Planes follow config writes through the config registers and the registered matrix product.
// Reset (rst_n, async low): identity matrices, pipeline emptied.
module frustum_aabb_cull_core #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // min_x, min_y, min_z, max_x, max_y, max_z
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // inside_res, zero padded
    output logic [7:0]                           m_axis_tdata,
    input  logic                                 cfg_wr_en,
    input  logic [3:0]                           cfg_index,
    input  logic [63:0]                          cfg_data
);
    localparam int BW = 6*COORD_WIDTH;
    fac_pkg::plane_t planes [fac_pkg::NPLANE];
    logic [BW-1:0] box [fac_pkg::NPLANE+1];
    logic ok [fac_pkg::NPLANE+1];
    logic [fac_pkg::NPLANE-1:0] vld_reg;
    logic adv;

    fac_plane_gen u_planes (
        .clk(clk), .rst_n(rst_n), .wr_en(cfg_wr_en), .wr_index(cfg_index),
        .wr_data(cfg_data), .planes(planes)
    );

    // advance whenever the last slot is empty or being taken
    assign adv = !vld_reg[fac_pkg::NPLANE-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign box[0] = s_axis_tdata[BW-1:0];
    assign ok[0]  = 1'b1;

    for (genvar i = 0; i < fac_pkg::NPLANE; i++)
    begin : g_cell
        fac_cell #(.COORD_WIDTH(COORD_WIDTH)) u_cell (
            .clk(clk), .en(adv), .plane(planes[i]), .box_in(box[i]),
            .ok_in(ok[i]), .box_out(box[i+1]), .ok_out(ok[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[fac_pkg::NPLANE-2:0], s_axis_tvalid};
    end

    assign m_axis_tvalid = vld_reg[fac_pkg::NPLANE-1];
    assign m_axis_tdata  = {7'd0, ok[fac_pkg::NPLANE]};
endmodule

[hw/rtl/fac_checker.sv]
// Port-level checker for the frustum cull core, bound to the top level.
`include "frustum_aabb_cull_core_defines.svh"
module fac_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);
    `FAC_ASSERT_IMPL(a_pad, clk, rst_n, m_axis_tvalid, m_axis_tdata[7:1] == 7'd0)
    `FAC_ASSERT_IMPL(a_rdy, clk, rst_n, !m_axis_tvalid, s_axis_tready)
    `FAC_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule

bind frustum_aabb_cull_core fac_checker u_fac_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
